// ===== rtl/core/dqs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque with search - shared definitions
// Operation and error codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package dqs_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int ERR_W     = 2;
  localparam int DEPTH_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

endpackage

// ===== rtl/core/dqs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque entry store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module dqs_ram #(
  parameter int DEPTH = dqs_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_addr,
  input  logic [dqs_pkg::DATA_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [IDX_W-1:0]          rd_addr,
  output logic [dqs_pkg::DATA_W-1:0] rd_data
);
  import dqs_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/deque_with_membership_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque with membership search - top level
// Push, pop and clear: result strobed in the cycle after start, busy stays low.
// Search: result once all held entries have been read and compared, busy meanwhile;
//   one store read per cycle through the shared compare unit sets the pace.
// Results cannot be stalled. Reset clears front index and count; the entry
//   store is not cleared and is only read at held entries.
// ----------------------------------------------------------------------------
module deque_with_membership_search #(
  parameter int DEPTH = dqs_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [dqs_pkg::OP_W-1:0]          in_operation,
  input  logic signed [dqs_pkg::DATA_W-1:0] in_data_value,
  output logic                              out_valid,
  output logic                              out_found,
  output logic [dqs_pkg::ERR_W-1:0]         out_error_code,
  output logic [CNT_W-1:0]                  out_entry_count
);
  import dqs_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W:0]   DEPTH_X  = (CNT_W + 1)'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   front_r, front_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   scan_ptr_r, scan_ptr_nxt;
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               hit_r, hit_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  key_r, key_nxt;
  logic               out_found_r, out_found_nxt;
  err_t               out_err_r, out_err_nxt;
  logic [CNT_W-1:0]   out_count_r, out_count_nxt;

  logic               accept;
  logic               is_full;
  logic               is_empty;
  logic [CNT_W:0]     back_sum;
  logic [IDX_W-1:0]   back_slot;
  logic [IDX_W-1:0]   front_prev;
  logic [IDX_W-1:0]   front_next;
  logic               issue;
  logic               match;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [DATA_W-1:0]  rd_data;

  dqs_ram #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data_value),
    .rd_en   (issue),
    .rd_addr (scan_ptr_r),
    .rd_data (rd_data)
  );

  assign accept     = start && (state_r == ST_IDLE);
  assign is_full    = (count_r == FULL_CNT);
  assign is_empty   = (count_r == '0);
  assign back_sum   = {{(CNT_W + 1 - IDX_W){1'b0}}, front_r} + {1'b0, count_r};
  assign back_slot  = (back_sum >= DEPTH_X) ? IDX_W'(back_sum - DEPTH_X)
                                            : IDX_W'(back_sum);
  assign front_prev = (front_r == '0) ? LAST_IDX : front_r - 1'b1;
  assign front_next = (front_r == LAST_IDX) ? '0 : front_r + 1'b1;
  assign issue      = (state_r == ST_SCAN) && (scan_idx_r != count_r);
  assign match      = rd_pend_r && (rd_data == key_r);

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    scan_ptr_nxt  = scan_ptr_r;
    scan_idx_nxt  = scan_idx_r;
    rd_pend_nxt   = 1'b0;
    hit_nxt       = hit_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_err_nxt   = out_err_r;
    out_count_nxt = out_count_r;
    wr_en         = 1'b0;
    wr_addr       = back_slot;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_found_nxt = 1'b0;
          out_err_nxt   = ERR_OK;
          out_valid_nxt = 1'b1;
          unique case (op_t'(in_operation))
            OP_PUSH_FRONT: begin
              if (is_full) begin
                out_err_nxt = ERR_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = front_prev;
                front_nxt = front_prev;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                out_err_nxt = ERR_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                out_err_nxt = ERR_EMPTY;
              end else begin
                front_nxt = front_next;
                count_nxt = count_r - 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                out_err_nxt = ERR_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            OP_SEARCH: begin
              out_valid_nxt = 1'b0;
              key_nxt       = in_data_value;
              scan_ptr_nxt  = front_r;
              scan_idx_nxt  = '0;
              hit_nxt       = 1'b0;
              state_nxt     = ST_SCAN;
            end
            OP_CLEAR: begin
              front_nxt = '0;
              count_nxt = '0;
            end
            default: begin
            end
          endcase
          out_count_nxt = count_nxt;
        end
      end
      ST_SCAN: begin
        hit_nxt = hit_r || match;
        if (issue) begin
          rd_pend_nxt  = 1'b1;
          scan_idx_nxt = scan_idx_r + 1'b1;
          scan_ptr_nxt = (scan_ptr_r == LAST_IDX) ? '0 : scan_ptr_r + 1'b1;
        end else begin
          out_valid_nxt = 1'b1;
          out_found_nxt = hit_r || match;
          out_err_nxt   = ERR_OK;
          out_count_nxt = count_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_ptr_r  <= scan_ptr_nxt;
    scan_idx_r  <= scan_idx_nxt;
    hit_r       <= hit_nxt;
    key_r       <= key_nxt;
    out_found_r <= out_found_nxt;
    out_err_r   <= out_err_nxt;
    out_count_r <= out_count_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_error_code  = out_err_r;
  assign out_entry_count = out_count_r;

endmodule
